// ----- hdl/pqi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqi_pkg
// Types and codes shared by the panel input qualifier modules.
// ----------------------------------------------------------------------------
package pqi_pkg;

   localparam int THRESHOLD_WIDTH = 4;
   localparam logic [THRESHOLD_WIDTH-1:0] THRESHOLD_RESET = 4'd8;

   localparam logic [1:0] TRANS_NONE = 2'd0;
   localparam logic [1:0] TRANS_RISE = 2'd1;
   localparam logic [1:0] TRANS_FALL = 2'd2;

   localparam logic [1:0] STEP_NONE = 2'd0;
   localparam logic [1:0] STEP_CW   = 2'd1;
   localparam logic [1:0] STEP_CCW  = 2'd2;

   typedef struct packed {
      logic toggle_pin_n;
      logic push_pin_n;
      logic knob_push_pin_n;
      logic phase_a_pin_n;
      logic phase_b_pin_n;
   } req_type;

   typedef struct packed {
      logic       toggle_level;
      logic [1:0] toggle_edge;
      logic       push_level;
      logic [1:0] push_edge;
      logic       knob_push_level;
      logic [1:0] knob_push_edge;
      logic [1:0] turn_step;
   } rsp_type;

   // Result of one debounced switch for the current tick
   typedef struct packed {
      logic       level;
      logic [1:0] edge_code;
   } switch_result_type;

endpackage

// ----- hdl/pqi_debounce.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqi_debounce
// One switch: saturating stable-sample counter, debounced level, edge code.
// ----------------------------------------------------------------------------
module pqi_debounce
   import pqi_pkg::*;
#(
   parameter int COUNT_WIDTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       sample,
   input  logic [THRESHOLD_WIDTH-1:0] threshold,
   output switch_result_type          result
);

   localparam int CMP_WIDTH = (COUNT_WIDTH > THRESHOLD_WIDTH) ? COUNT_WIDTH : THRESHOLD_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   logic                   prev_sample_ff, prev_sample_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   level_ff, level_in;
   logic [COUNT_WIDTH-1:0] count_step;

   always_comb begin
      if (sample == prev_sample_ff) begin
         count_step = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_WIDTH'(1);
      end else begin
         count_step = '0;
      end
      level_in = level_ff;
      count_in = count_step;
      if (CMP_WIDTH'(count_step) > CMP_WIDTH'(threshold)) begin
         level_in = sample;
         count_in = '0;
      end
      prev_sample_in = sample;
   end

   always_comb begin
      result.level = level_in;
      if (level_in == level_ff) begin
         result.edge_code = TRANS_NONE;
      end else if (level_in) begin
         result.edge_code = TRANS_RISE;
      end else begin
         result.edge_code = TRANS_FALL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_sample_ff <= 1'b0;
         count_ff       <= '0;
         level_ff       <= 1'b0;
      end else if (advance) begin
         prev_sample_ff <= prev_sample_in;
         count_ff       <= count_in;
         level_ff       <= level_in;
      end
   end

endmodule

// ----- hdl/pqi_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqi_step
// Quadrature step decoder: one step per rising edge of phase A.
// ----------------------------------------------------------------------------
module pqi_step
   import pqi_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic       phase_a,
   input  logic       phase_b,
   output logic [1:0] step
);

   logic prev_a_ff;

   always_comb begin
      if (!prev_a_ff && phase_a) begin
         step = phase_b ? STEP_CW : STEP_CCW;
      end else begin
         step = STEP_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_a_ff <= 1'b0;
      end else if (advance) begin
         prev_a_ff <= phase_a;
      end
   end

endmodule

// ----- hdl/panel_input_qualifier_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// panel_input_qualifier_top
// Front-panel switch debouncer with edge detect and quadrature step decoder.
// ----------------------------------------------------------------------------
// Path: a request is accepted into the input register, then moves to the
//   result register, where rsp_valid rises.
// Throughput: one request per cycle while rsp_ready is high; set by the single result register,
//   which reloads in the cycle it is taken.
// Reset: synchronous, active high. Clears all switch state, both valid
//   flags, and loads hold_threshold with 8.
// ----------------------------------------------------------------------------
module panel_input_qualifier_top
   import pqi_pkg::*;
#(
   parameter int COUNT_WIDTH = 4   // stable counter width, 2..8
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel: one sampling tick of the raw active-low pins
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_type                    req_data,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_type                    rsp_data,
   // hold_threshold register write
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [THRESHOLD_WIDTH-1:0] csr_data
);

   // Threshold register. The user must write it only while the block is idle; the block does not enforce this.
   logic [THRESHOLD_WIDTH-1:0] threshold_ff;

   // Input stage holds the raw pins of one request.
   req_type req_data_ff;
   logic    req_valid_ff;

   // Result stage.
   rsp_type rsp_data_ff, rsp_data_in;
   logic    rsp_valid_ff;

   logic    out_free;   // result register can take a new value
   logic    advance;    // input stage moves to result stage, state updates
   logic [2:0]        sample;
   switch_result_type sw_result [3];
   logic [1:0]        step;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         threshold_ff <= csr_data;
      end
   end

   // Pipeline handshake: a stage takes new data when empty or when it drains
   // in the same cycle, so a full-rate stream never bubbles.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = req_valid_ff && out_free;
   assign req_ready = !req_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_data_ff <= req_data;
      end
   end

   // Pins are active low: invert to logical level (1 = on / pressed).
   assign sample = {~req_data_ff.knob_push_pin_n,
                    ~req_data_ff.push_pin_n,
                    ~req_data_ff.toggle_pin_n};

   // One debouncer per switch: toggle, pushbutton, encoder push.
   for (genvar gi = 0; gi < 3; gi++) begin : g_switch
      pqi_debounce #(
         .COUNT_WIDTH (COUNT_WIDTH)
      ) u_debounce (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .sample    (sample[gi]),
         .threshold (threshold_ff),
         .result    (sw_result[gi])
      );
   end

   pqi_step u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .phase_a (~req_data_ff.phase_a_pin_n),
      .phase_b (~req_data_ff.phase_b_pin_n),
      .step    (step)
   );

   always_comb begin
      rsp_data_in.toggle_level    = sw_result[0].level;
      rsp_data_in.toggle_edge     = sw_result[0].edge_code;
      rsp_data_in.push_level      = sw_result[1].level;
      rsp_data_in.push_edge       = sw_result[1].edge_code;
      rsp_data_in.knob_push_level = sw_result[2].level;
      rsp_data_in.knob_push_edge  = sw_result[2].edge_code;
      rsp_data_in.turn_step       = step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= advance;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hdl/pqi_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqi_checker
// Port-level checks for the panel input qualifier, bound to the top level.
// ----------------------------------------------------------------------------
module pqi_checker
   import pqi_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A stalled result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Toggle rising edge code only with the new level on
   a_toggle_rise: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.toggle_edge == TRANS_RISE |-> rsp_data.toggle_level)
      else $error("toggle rise with level low");

   // Push falling edge code only with the new level off
   a_push_fall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.push_edge == TRANS_FALL |-> !rsp_data.push_level)
      else $error("push fall with level high");

   // Reset empties the result stage
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind panel_input_qualifier_top pqi_checker u_pqi_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ----- dv/panel_input_qualifier_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// panel_input_qualifier_checker
// Watches the request, response and threshold channels of the panel input
// qualifier and predicts each response. Responses are compared field by
// field, in order, against the predicted panel results.
// ----------------------------------------------------------------------------
module panel_input_qualifier_checker
   import pqi_pkg::*;
#(
   parameter int COUNT_WIDTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  req_type                    req_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  rsp_type                    rsp_data,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [THRESHOLD_WIDTH-1:0] csr_data,
   output int                         mismatches,
   output int                         awaiting,
   output int                         results_seen
);

   localparam logic [COUNT_WIDTH-1:0] RUN_SAT = {COUNT_WIDTH{1'b1}};

   // predictor copy of the block state
   logic [THRESHOLD_WIDTH-1:0] hold_limit;
   logic [2:0]                 last_sample;
   logic [COUNT_WIDTH-1:0]     stable_run [3];
   logic [2:0]                 settled;
   logic                       last_phase_a;

   rsp_type expected_panel_results [$];
   rsp_type predicted;
   rsp_type oldest;

   function automatic logic [1:0] edge_of(input logic prior, input logic latest);
      if (prior == latest)
         return TRANS_NONE;
      return latest ? TRANS_RISE : TRANS_FALL;
   endfunction

   task automatic qualify_tick(input req_type pins, output rsp_type res);
      logic [2:0] sample;
      logic [2:0] was;
      logic       phase_a;
      logic       phase_b;
      int         i;
      sample  = {~pins.knob_push_pin_n, ~pins.push_pin_n, ~pins.toggle_pin_n};
      phase_a = ~pins.phase_a_pin_n;
      phase_b = ~pins.phase_b_pin_n;
      was     = settled;
      for (i = 0; i < 3; i++) begin
         if (sample[i] == last_sample[i]) begin
            if (stable_run[i] != RUN_SAT)
               stable_run[i] = stable_run[i] + 1'b1;
         end else begin
            stable_run[i] = '0;
         end
         if (stable_run[i] > hold_limit) begin
            settled[i]    = sample[i];
            stable_run[i] = '0;
         end
      end
      last_sample         = sample;
      res.toggle_level    = settled[0];
      res.toggle_edge     = edge_of(was[0], settled[0]);
      res.push_level      = settled[1];
      res.push_edge       = edge_of(was[1], settled[1]);
      res.knob_push_level = settled[2];
      res.knob_push_edge  = edge_of(was[2], settled[2]);
      if (!last_phase_a && phase_a)
         res.turn_step = phase_b ? STEP_CW : STEP_CCW;
      else
         res.turn_step = STEP_NONE;
      last_phase_a = phase_a;
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         hold_limit   = THRESHOLD_RESET;
         last_sample  = '0;
         settled      = '0;
         last_phase_a = 1'b0;
         for (int i = 0; i < 3; i++)
            stable_run[i] = '0;
         expected_panel_results.delete();
      end else begin
         // response side first: it belongs to an older request
         if (rsp_valid && rsp_ready) begin
            if (expected_panel_results.size() == 0) begin
               $error("response with no request outstanding: %h", rsp_data);
               mismatches++;
            end else begin
               oldest = expected_panel_results.pop_front();
               check_field("toggle_level", oldest.toggle_level, rsp_data.toggle_level);
               check_field("toggle_edge", oldest.toggle_edge, rsp_data.toggle_edge);
               check_field("push_level", oldest.push_level, rsp_data.push_level);
               check_field("push_edge", oldest.push_edge, rsp_data.push_edge);
               check_field("knob_push_level", oldest.knob_push_level,
                           rsp_data.knob_push_level);
               check_field("knob_push_edge", oldest.knob_push_edge,
                           rsp_data.knob_push_edge);
               check_field("turn_step", oldest.turn_step, rsp_data.turn_step);
               results_seen++;
            end
         end
         if (csr_valid && csr_ready)
            hold_limit = csr_data;
         if (req_valid && req_ready) begin
            qualify_tick(req_data, predicted);
            expected_panel_results.push_back(predicted);
         end
      end
      awaiting = expected_panel_results.size();
   end

endmodule

// ----- dv/panel_input_qualifier_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// panel_input_qualifier_top_test
// Drives sampling ticks of bouncing switch pins and a quadrature knob into
// the panel input qualifier, across several hold thresholds, with random
// stalls on both channels. A side checker predicts and compares responses.
// ----------------------------------------------------------------------------
module panel_input_qualifier_top_test;
   import pqi_pkg::*;

   localparam int COUNT_WIDTH  = 4;
   localparam int CYCLE_LIMIT  = 200000;  // far above the slowest clean run
   localparam int LONG_HOLD    = 300;     // receiver hold-off, in cycles
   localparam int PHASE_COUNT  = 7;
   localparam int PHASE_TICKS  = 70;

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   req_type                    req_data  = '1;     // all pins released
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   rsp_type                    rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [THRESHOLD_WIDTH-1:0] csr_data  = THRESHOLD_RESET;

   int mismatches;
   int awaiting;
   int results_seen;

   int cycle_count  = 0;
   int sent         = 0;
   int settings     = 0;

   // idling control shared by both sides
   bit calm          = 1'b0;   // set for the final phase: no idling at all
   bit rsp_long_hold = 1'b0;   // request for one long receiver hold-off
   int req_run_left  = 0;
   int rsp_run_left  = 0;
   int rsp_stall_left = 0;
   int hold_count;

   // stimulus model: bouncy switches and a quadrature knob
   logic [3:0]         cur_threshold = THRESHOLD_RESET;
   logic [2:0]         sw_target     = '0;
   int                 sw_hold [3]   = '{0, 0, 0};
   int                 sw_bounce [3] = '{0, 0, 0};
   logic [1:0]         quad_pos      = '0;

   always #1 clock = ~clock;

   panel_input_qualifier_top #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   panel_input_qualifier_checker #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .mismatches   (mismatches),
      .awaiting     (awaiting),
      .results_seen (results_seen)
   );

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Response side. rsp_ready is written nonblocking at falling edges.
   // Stall bursts are separated by random runs of ready cycles, so stalls
   // land on every phase of the pipeline.
   always begin
      @(negedge clock);
      if (rsp_long_hold) begin
         // long hold-off, counted here so the sender keeps pushing meanwhile
         rsp_ready <= 1'b0;
         for (hold_count = 1; hold_count < LONG_HOLD; hold_count++)
            @(negedge clock);
         rsp_long_hold = 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall_left--;
      end else if (!calm && rsp_run_left == 0) begin
         rsp_ready <= 1'b0;
         rsp_stall_left = $urandom_range(0, 15);
         rsp_run_left   = $urandom_range(0, 40);
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_run_left > 0)
            rsp_run_left--;
      end
   end

   // Active-low pins from logical levels.
   function automatic req_type pins_from(input logic [2:0] pressed, input logic a,
                                         input logic b);
      req_type t;
      t.toggle_pin_n    = ~pressed[0];
      t.push_pin_n      = ~pressed[1];
      t.knob_push_pin_n = ~pressed[2];
      t.phase_a_pin_n   = ~a;
      t.phase_b_pin_n   = ~b;
      return t;
   endfunction

   // Present one request at the falling edge and hold it until taken.
   // Valid is left high so a following request does not drop and re-raise
   // it in the same step.
   task automatic offer(input req_type t);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   // Sender idle gap: valid held low, payload scrambled meanwhile.
   task automatic idle_gap(input int n);
      @(negedge clock);
      req_valid <= 1'b0;
      req_data  <= 5'($urandom);
      repeat (n - 1) @(negedge clock);
   endtask

   // Called after each accepted request: a burst gap every 1..41 requests unless calm is set.
   task automatic pace_sender();
      if (!calm) begin
         if (req_run_left == 0) begin
            idle_gap($urandom_range(1, 16));
            req_run_left = $urandom_range(0, 40);
         end else begin
            req_run_left--;
         end
      end
   endtask

   // Stop sending and wait for every predicted response, plus some margin.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaiting != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_threshold(input logic [3:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      cur_threshold = value;
      settings++;
   endtask

   // Next sampling tick. Mostly well-formed: each switch holds a level for
   // a run scaled to the threshold, with a few bounce samples when a new
   // run starts; the knob walks the gray sequence either way. About one
   // tick in eight is pure pin noise.
   task automatic make_tick(output req_type t);
      logic [2:0] lvl;
      logic [1:0] gray;
      int         i;
      if ($urandom_range(0, 99) < 12) begin
         t = 5'($urandom);
      end else begin
         for (i = 0; i < 3; i++) begin
            if (sw_hold[i] == 0) begin
               sw_target[i] = 1'($urandom_range(0, 1));
               sw_hold[i]   = $urandom_range(1, 2 * cur_threshold + 6);
               sw_bounce[i] = $urandom_range(0, 4);
            end
            if (sw_bounce[i] > 0) begin
               lvl[i] = 1'($urandom_range(0, 1));
               sw_bounce[i]--;
            end else begin
               lvl[i] = sw_target[i];
               sw_hold[i]--;
            end
         end
         case ($urandom_range(0, 3))
            0: quad_pos = quad_pos + 1'b1;
            1: quad_pos = quad_pos - 1'b1;
            default: ;
         endcase
         gray = quad_pos ^ (quad_pos >> 1);
         t = pins_from(lvl, gray[1], gray[0]);
      end
   endtask

   initial begin
      req_type    tick;
      logic [2:0] pressed;
      logic [1:0] gray;
      logic [3:0] plan [PHASE_COUNT];
      int         k;
      int         ph;

      // Threshold plan: extremes first, saturation case (15), then mid
      // values; one random setting; final phase runs with no idling.
      plan[0] = 4'd0;
      plan[1] = 4'd14;
      plan[2] = 4'd15;
      plan[3] = 4'd1;
      plan[4] = 4'd3;
      plan[5] = 4'($urandom_range(0, 15));
      plan[6] = 4'd2;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset threshold: released, then all switches
      // pressed, then released again. Toggle and pushbutton stay pressed long
      // enough to settle; one bounce on the knob push keeps it from settling and
      // shows each switch counts on its own bit. The knob steps forward while
      // pressed and backward while released, giving both step directions.
      for (k = 0; k < 24; k++) begin
         if (k < 2)
            pressed = 3'b000;
         else if (k < 13)
            pressed = (k == 4) ? 3'b011 : 3'b111;
         else
            pressed = 3'b000;
         if (k >= 2 && k < 13)
            quad_pos = quad_pos + 1'b1;
         else if (k >= 13)
            quad_pos = quad_pos - 1'b1;
         gray = quad_pos ^ (quad_pos >> 1);
         offer(pins_from(pressed, gray[1], gray[0]));
         pace_sender();
      end

      // Random phases, one threshold each, written only with the block idle.
      for (ph = 0; ph < PHASE_COUNT; ph++) begin
         settle();
         write_threshold(plan[ph]);
         if (ph == PHASE_COUNT - 1)
            calm = 1'b1;
         for (k = 0; k < PHASE_TICKS; k++) begin
            // long response stall while requests keep coming: fills the
            // block and backs up the request side
            if (ph == 1 && k == 10)
               rsp_long_hold = 1'b1;
            // sender pause until every response is back
            if (ph == 3 && k == 35)
               settle();
            make_tick(tick);
            offer(tick);
            pace_sender();
         end
      end

      settle();
      repeat (8) @(negedge clock);

      $display("Run covered %0d requests and %0d checked responses over %0d thresholds",
               sent, results_seen, settings + 1);
      $display("including bouncing switches, both knob directions, a long stall and a drain");
      if (mismatches == 0 && awaiting == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
